// File: design/rdrc_pkg.sv
// rdrc_pkg: shared types and constants for the receive descriptor ring frame check unit
// holds the request and response item structs, opcode codes and controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package rdrc_pkg;

	localparam int RING_DEPTH_DEF  = 8;
	localparam int LENGTH_BITS_DEF = 14;

	localparam int IDX_W     = 3;
	localparam int OUT_LEN_W = 14;
	localparam int WB_LEN_W  = 14;
	localparam int CRC_BYTES = 4;

	localparam logic [IDX_W-1:0] OP_WRITEBACK = 3'd0;
	localparam logic [IDX_W-1:0] OP_CHECK     = 3'd1;
	localparam logic [IDX_W-1:0] OP_RELEASE   = 3'd2;
	localparam logic [IDX_W-1:0] OP_ADVANCE   = 3'd3;
	localparam logic [IDX_W-1:0] OP_QUERY     = 3'd4;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [IDX_W-1:0]    slot_index;
		logic                wb_first;
		logic                wb_last;
		logic [WB_LEN_W-1:0] wb_frame_length;
	} req_item_t;

	typedef struct packed {
		logic [OUT_LEN_W-1:0] frame_length;
		logic                 frame_valid;
		logic                 cur_owned_by_dma;
		logic                 cur_first;
		logic                 cur_last;
		logic [IDX_W-1:0]     cur_index;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic look;
		logic step;
		logic finish;
		logic rd_cur;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_check;
		logic walk_done;
	} ctl_sts_t;

endpackage

// File: design/rx_descriptor_ring_frame_check_unit.sv
// rx_descriptor_ring_frame_check_unit: top level of the receive descriptor ring frame check
// ties the controller (rdrc_ctrl) to the datapath (rdrc_dpath), depends on rdrc_pkg
//
// channel  | signals                       | direction | content
// ---------+-------------------------------+-----------+----------------------------------
// request  | req_valid, req_stall, req     | in        | opcode, slot, writeback fields
// response | rsp_valid, rsp_stall, rsp     | out       | check result, current slot view
//
// writeback, release, advance and query pass through the reread and hold states before the response
// a frame check first walks the slots of the frame (1 .. RING_DEPTH of them),
// reading one descriptor per cycle from the single ram read port
// one request is in work at a time; req_stall is high from the cycle after the transfer
// until the result sits in the response register, which may still wait on rsp_stall
// arst_n gives every slot to dma and points at slot zero; no clearing pass is needed
`timescale 1ns / 1ps

module rx_descriptor_ring_frame_check_unit #(
	parameter int RING_DEPTH  = rdrc_pkg::RING_DEPTH_DEF,
	parameter int LENGTH_BITS = rdrc_pkg::LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  rdrc_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rdrc_pkg::rsp_item_t  rsp
);

	// command and status between the state machine and the datapath
	rdrc_pkg::ctl_cmd_t ctl;
	rdrc_pkg::ctl_sts_t sts;

	// sequencer: accept, walk the ring for a frame check, reread the current slot, load the response
	rdrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// descriptor ram, ownership bits, pointer, walk unit and response register
	rdrc_dpath #(
		.RING_DEPTH (RING_DEPTH),
		.LENGTH_BITS(LENGTH_BITS)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.req   (req),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

// File: design/rdrc_ram.sv
// rdrc_ram: generic single write, single read ram with registered read data
// read data holds while no read is issued
// no dependencies
`timescale 1ns / 1ps

module rdrc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/rdrc_ctrl.sv
// rdrc_ctrl: sequencing state machine of the frame check unit
// drives datapath commands and the response valid, depends on rdrc_pkg
`timescale 1ns / 1ps

module rdrc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  rdrc_pkg::ctl_sts_t  sts,
	output rdrc_pkg::ctl_cmd_t  ctl
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LOOK   = 5'b00010,
		ST_WALK   = 5'b00100,
		ST_REREAD = 5'b01000,
		ST_HOLD   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   acc;

	assign req_stall = (state_q != ST_IDLE);
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					ctl.accept = 1'b1;
					state_d    = sts.is_check ? ST_LOOK : ST_REREAD;
				end
			end
			ST_LOOK: begin
				ctl.look = 1'b1;
				state_d  = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					ctl.finish = 1'b1;
					state_d    = ST_REREAD;
				end else begin
					ctl.step = 1'b1;
				end
			end
			ST_REREAD: begin
				ctl.rd_cur = 1'b1;
				state_d    = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_valid_q || !rsp_stall) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_check_enters_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && sts.is_check) |=> (state_q == ST_LOOK))
		else $error("frame check did not start its walk");

	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && !sts.walk_done) |=> (state_q == ST_WALK))
		else $error("walk left before reaching its end");

	a_hold_until_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && out_valid_q && rsp_stall) |=> (state_q == ST_HOLD))
		else $error("result overwrote a pending response");

endmodule

// File: design/rdrc_dpath.sv
// rdrc_dpath: descriptor storage, ownership bits, slot pointer, walk unit and response register
// depends on rdrc_pkg and rdrc_ram
`timescale 1ns / 1ps

module rdrc_dpath #(
	parameter int RING_DEPTH  = rdrc_pkg::RING_DEPTH_DEF,
	parameter int LENGTH_BITS = rdrc_pkg::LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rdrc_pkg::ctl_cmd_t   ctl,
	input  rdrc_pkg::req_item_t  req,
	output rdrc_pkg::ctl_sts_t   sts,
	output rdrc_pkg::rsp_item_t  rsp
);

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int CMP_W  = $clog2(RING_DEPTH) + rdrc_pkg::IDX_W + 1;
	localparam int WORD_W = LENGTH_BITS + 2;

	// valid bit set means cpu owned and ram word meaningful
	logic [RING_DEPTH-1:0]         own_cpu_q;
	logic [PTR_W-1:0]              ptr_q;
	logic [PTR_W-1:0]              walk_idx_q;
	logic [CNT_W-1:0]              walk_cnt_q;
	logic                          first_q;
	logic                          rd_valid_s1;
	logic [rdrc_pkg::OUT_LEN_W-1:0] res_len_q;
	logic                          res_valid_q;
	rdrc_pkg::rsp_item_t           rsp_q;

	logic [PTR_W-1:0]  ptr_next, walk_next, raddr, waddr;
	logic              we, re, wb_in_range;
	logic [WORD_W-1:0] wdata, rdata;

	logic                           ent_owned, ent_first, ent_last;
	logic [LENGTH_BITS-1:0]         ent_len;
	logic                           bad_start, stop, exhausted, frame_ok;
	logic [rdrc_pkg::OUT_LEN_W-1:0] frame_len;

	assign ptr_next  = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign walk_next = (walk_idx_q == PTR_W'(RING_DEPTH - 1)) ? '0 : walk_idx_q + 1'b1;

	assign wb_in_range = CMP_W'(req.slot_index) < CMP_W'(RING_DEPTH);
	assign we    = ctl.accept && (req.opcode == rdrc_pkg::OP_WRITEBACK) && wb_in_range;
	assign waddr = PTR_W'(req.slot_index);
	assign wdata = {req.wb_first, req.wb_last, LENGTH_BITS'(req.wb_frame_length)};
	assign re    = ctl.look || ctl.step || ctl.rd_cur;
	assign raddr = ctl.step ? walk_next : ptr_q;

	rdrc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// slot seen through its ownership bit, dma owned reads as reset value
	assign ent_owned = !rd_valid_s1;
	assign ent_first = rd_valid_s1 && rdata[WORD_W-1];
	assign ent_last  = rd_valid_s1 && rdata[WORD_W-2];
	assign ent_len   = rd_valid_s1 ? rdata[LENGTH_BITS-1:0] : '0;

	assign bad_start = first_q && (ent_owned || !ent_first);
	assign stop      = ent_owned || ent_last;
	assign exhausted = !stop && (walk_cnt_q >= CNT_W'(RING_DEPTH));
	assign frame_ok  = !bad_start && !ent_owned && ent_last;
	assign frame_len = (ent_len < LENGTH_BITS'(rdrc_pkg::CRC_BYTES)) ? '0 :
		rdrc_pkg::OUT_LEN_W'(ent_len - LENGTH_BITS'(rdrc_pkg::CRC_BYTES));

	assign sts.is_check  = (req.opcode == rdrc_pkg::OP_CHECK);
	assign sts.walk_done = bad_start || stop || exhausted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_cpu_q  <= '0;
			ptr_q      <= '0;
			walk_cnt_q <= '0;
			first_q    <= 1'b0;
		end else begin
			if (we) begin
				own_cpu_q[waddr] <= 1'b1;
			end
			if (ctl.accept && (req.opcode == rdrc_pkg::OP_RELEASE)) begin
				own_cpu_q[ptr_q] <= 1'b0;
			end
			if (ctl.accept && (req.opcode == rdrc_pkg::OP_ADVANCE)) begin
				ptr_q <= ptr_next;
			end
			if (ctl.look) begin
				walk_cnt_q <= CNT_W'(1);
				first_q    <= 1'b1;
			end else if (ctl.step) begin
				walk_cnt_q <= walk_cnt_q + 1'b1;
				first_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_valid_s1 <= own_cpu_q[raddr];
		end
		if (ctl.look) begin
			walk_idx_q <= ptr_q;
		end else if (ctl.step) begin
			walk_idx_q <= walk_next;
		end
		if (ctl.accept) begin
			res_len_q   <= '0;
			res_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			res_valid_q <= frame_ok;
			res_len_q   <= frame_ok ? frame_len : '0;
		end
		if (ctl.load_out) begin
			rsp_q.frame_length     <= res_len_q;
			rsp_q.frame_valid      <= res_valid_q;
			rsp_q.cur_owned_by_dma <= ent_owned;
			rsp_q.cur_first        <= ent_first;
			rsp_q.cur_last         <= ent_last;
			rsp_q.cur_index        <= rdrc_pkg::IDX_W'(ptr_q);
		end
	end

	assign rsp = rsp_q;

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		walk_cnt_q <= CNT_W'(RING_DEPTH))
		else $error("walk went past the ring depth");

	a_writeback_owns: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> own_cpu_q[$past(waddr)])
		else $error("writeback did not hand the slot to the cpu");

	a_release_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && (req.opcode == rdrc_pkg::OP_RELEASE) && !we)
		|=> !own_cpu_q[$past(ptr_q)])
		else $error("release left the slot cpu owned");

endmodule
